// File: rtl/twt_pkg.sv
// Package for the tag identifier whitelist table: opcodes, microcode word,
// sequencer status, the microprogram and the byte mask helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twt_pkg;

    localparam int TableSlotsDefault  = 16;
    localparam int MaxTagBytesDefault = 8;
    localparam int TagBytesW          = 64;
    localparam int TagLenW            = 4;
    localparam int OpW                = 2;
    localparam int UpcW               = 2;
    localparam int UcodeDepth         = 4;

    typedef enum logic [OpW-1:0] {
        OP_ADD      = 2'd0,
        OP_DELETE   = 2'd1,
        OP_VALIDATE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        COND_IN_VALID = 2'd0,
        COND_BAD_REQ  = 2'd1,
        COND_DONE     = 2'd2,
        COND_OUT_FREE = 2'd3
    } cond_t;

    typedef logic [UpcW-1:0] upc_t;

    localparam upc_t StepIdle = 2'd0;
    localparam upc_t StepRead = 2'd1;
    localparam upc_t StepScan = 2'd2;
    localparam upc_t StepEmit = 2'd3;

    typedef struct packed {
        logic  ready;
        logic  scan;
        logic  emit;
        logic  hold;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic bad_req;
        logic done;
        logic out_free;
    } seq_status_t;

    function automatic ucode_t ucode_rom(input upc_t step);
        ucode_t w;
        w = '0;
        case (step)
            StepIdle: begin
                w.ready  = 1'b1;
                w.hold   = 1'b1;
                w.cond   = COND_IN_VALID;
                w.target = StepRead;
            end
            StepRead: begin
                w.cond   = COND_BAD_REQ;
                w.target = StepEmit;
            end
            StepScan: begin
                w.scan   = 1'b1;
                w.hold   = 1'b1;
                w.cond   = COND_DONE;
                w.target = StepEmit;
            end
            StepEmit: begin
                w.emit   = 1'b1;
                w.hold   = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.target = StepIdle;
            end
            default: begin
                w.cond   = COND_OUT_FREE;
                w.target = StepIdle;
            end
        endcase
        return w;
    endfunction

    function automatic logic [TagBytesW-1:0] byte_mask(input logic [TagLenW-1:0] len);
        logic [TagBytesW-1:0] m;
        m = '0;
        for (int b = 0; b < TagBytesW / 8; b++) begin
            if (TagLenW'(b) < len) begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/twt_sequencer.sv
// Microcode sequencer: step counter, control word table and conditional jumps.
// Depends on twt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twt_sequencer (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  twt_pkg::seq_status_t status,
    output twt_pkg::ucode_t      ctl
);
    import twt_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic cond_true;

    assign ctl = ucode_rom(upc_reg);

    always_comb begin
        case (ctl.cond)
            COND_IN_VALID: cond_true = status.in_valid;
            COND_BAD_REQ:  cond_true = status.bad_req;
            COND_DONE:     cond_true = status.done;
            COND_OUT_FREE: cond_true = status.out_free;
            default:       cond_true = 1'b0;
        endcase
        if (cond_true) begin
            upc_next = ctl.target;
        end else if (ctl.hold) begin
            upc_next = upc_reg;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= StepIdle;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/twt_datapath.sv
// Datapath: request registers, slot counter, slot memory with valid bits,
// and the match compare. Depends on twt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twt_datapath #(
    parameter int TABLE_SLOTS   = twt_pkg::TableSlotsDefault,
    parameter int MAX_TAG_BYTES = twt_pkg::MaxTagBytesDefault
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  twt_pkg::ucode_t                  ctl,
    input  wire                              in_accept,
    input  wire  [twt_pkg::OpW-1:0]          in_opcode,
    input  wire  [twt_pkg::TagBytesW-1:0]    in_tag_bytes,
    input  wire  [twt_pkg::TagLenW-1:0]      in_tag_length,
    output logic                             bad_req,
    output logic                             done,
    output logic                             ok
);
    import twt_pkg::*;

    localparam int SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [SlotW-1:0] LastSlot = SlotW'(TABLE_SLOTS - 1);

    logic [OpW-1:0]       op_reg;
    logic [TagBytesW-1:0] bytes_reg;
    logic [TagLenW-1:0]   len_reg;
    logic [SlotW-1:0]     slot_reg;
    logic                 ok_reg;

    logic [TagBytesW-1:0] mem_bytes [TABLE_SLOTS];
    logic [TagLenW-1:0]   mem_len   [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] valid_reg;

    logic [TagBytesW-1:0] rd_bytes_reg;
    logic [TagLenW-1:0]   rd_len_reg;
    logic                 rd_valid_reg;

    logic [SlotW-1:0] rd_addr;
    logic             last_slot;
    logic             empty;
    logic             match;
    logic             hit;
    logic             do_write;
    logic             do_clear;

    assign last_slot = (slot_reg == LastSlot);
    assign rd_addr   = (ctl.scan && !last_slot) ? slot_reg + 1'b1 : slot_reg;

    assign bad_req = (len_reg == '0) || (len_reg > TagLenW'(MAX_TAG_BYTES))
                     || !(op_reg inside {OP_ADD, OP_DELETE, OP_VALIDATE});

    assign empty = !rd_valid_reg;
    assign match = rd_valid_reg && (rd_len_reg == len_reg) && (rd_bytes_reg == bytes_reg);

    always_comb begin
        hit      = 1'b0;
        do_write = 1'b0;
        do_clear = 1'b0;
        case (opcode_t'(op_reg))
            OP_ADD: begin
                hit      = empty || match;
                do_write = empty;
            end
            OP_DELETE: begin
                hit      = match;
                do_clear = match;
            end
            OP_VALIDATE: begin
                hit = match;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    assign done = hit || last_slot;
    assign ok   = ok_reg;

    always_ff @(posedge aclk) begin
        if (ctl.ready && in_accept) begin
            op_reg    <= in_opcode;
            bytes_reg <= in_tag_bytes & byte_mask(in_tag_length);
            len_reg   <= in_tag_length;
            slot_reg  <= '0;
            ok_reg    <= 1'b0;
        end else if (ctl.scan) begin
            if (hit) begin
                ok_reg <= 1'b1;
            end
            if (!done) begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.scan && do_write) begin
            mem_bytes[slot_reg] <= bytes_reg;
            mem_len[slot_reg]   <= len_reg;
        end
        rd_bytes_reg <= mem_bytes[rd_addr];
        rd_len_reg   <= mem_len[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.scan && do_write) begin
            valid_reg[slot_reg] <= 1'b1;
        end else if (ctl.scan && do_clear) begin
            valid_reg[slot_reg] <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tag_id_whitelist_table.sv
// Top level of the tag identifier whitelist table: stream ports, result
// register, sequencer and datapath. Depends on twt_pkg, twt_sequencer, twt_datapath.
//
// Channel  Dir  tdata fields (low bit first)                       Width
// s_       in   opcode[1:0], tag_bytes[65:2], tag_length[69:66]     72
// m_       out  ok[0]                                               8
//
// A request is taken in the idle step, then passes the read, scan and emit steps; the
// scan covers N (1 to TABLE_SLOTS) slots, one slot compared per cycle through the slot memory read port.
// Invalid requests skip the scan step. Reset empties every slot at once.
// A result waiting on m_tready stalls only the next request's final step.
`timescale 1ns / 1ps
`default_nettype none

module tag_id_whitelist_table #(
    parameter int TABLE_SLOTS   = twt_pkg::TableSlotsDefault,
    parameter int MAX_TAG_BYTES = twt_pkg::MaxTagBytesDefault
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // opcode, tag_bytes, tag_length, zero pad
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata    // ok, zero pad
);
    import twt_pkg::*;

    ucode_t      ctl;
    seq_status_t status;
    logic        bad_req;
    logic        done;
    logic        ok;
    logic        out_free;
    logic        m_tvalid_reg;
    logic        m_ok_reg;

    assign s_tready = ctl.ready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign status.in_valid = s_tvalid;
    assign status.bad_req  = bad_req;
    assign status.done     = done;
    assign status.out_free = out_free;

    twt_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctl     (ctl)
    );

    twt_datapath #(
        .TABLE_SLOTS   (TABLE_SLOTS),
        .MAX_TAG_BYTES (MAX_TAG_BYTES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .in_accept     (s_tvalid),
        .in_opcode     (s_tdata[1:0]),
        .in_tag_bytes  (s_tdata[65:2]),
        .in_tag_length (s_tdata[69:66]),
        .bad_req       (bad_req),
        .done          (done),
        .ok            (ok)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.emit && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit && out_free) begin
            m_ok_reg <= ok;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_ok_reg};

endmodule

`default_nettype wire

// File: tb/sv/tag_id_whitelist_table_test.sv
// Self-checking testbench for tag_id_whitelist_table: a queue-fed stream driver,
// a result monitor and an in-bench model of the slot table predict every response.
// Depends on twt_pkg and the tag_id_whitelist_table RTL.
`timescale 1ns / 1ps

module tag_id_whitelist_table_test;

    import twt_pkg::*;

    localparam int TableSlots       = 16;
    localparam int MaxTagBytes      = 8;
    localparam int PoolSize         = 24;
    localparam int RandomPerPhase   = 150;
    localparam logic [1:0] OpUnused = 2'd3;

    typedef struct {
        logic [1:0]  opcode;
        logic [63:0] tag_bytes;
        logic [3:0]  tag_length;
    } tag_request_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;    // opcode, tag_bytes, tag_length, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // ok, zero pad

    tag_request_t pending_requests[$];
    tag_request_t request_on_bus;
    logic         ok_expected[$];

    logic [63:0] table_bytes[TableSlots];
    logic [3:0]  table_length[TableSlots];
    logic [63:0] pool_bytes[PoolSize];
    logic [3:0]  pool_length[PoolSize];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int fail_count = 0;

    tag_id_whitelist_table #(
        .TABLE_SLOTS  (TableSlots),
        .MAX_TAG_BYTES(MaxTagBytes)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] tag_mask(input logic [3:0] len);
        return ~({64{1'b1}} << (8 * int'(len)));
    endfunction

    // Updates the table copy for one request and returns the ok it should produce.
    function automatic logic apply_request(input tag_request_t r);
        logic [63:0] key;
        logic        ok;
        logic        found;
        logic        done;
        ok = 1'b0;
        done = 1'b0;
        if (r.tag_length != 0 && int'(r.tag_length) <= MaxTagBytes) begin
            key = r.tag_bytes & tag_mask(r.tag_length);
            for (int i = 0; i < TableSlots && !done; i++) begin
                found = (table_length[i] == r.tag_length) && (table_bytes[i] == key);
                case (r.opcode)
                    OP_ADD: begin
                        if (table_length[i] == 0) begin
                            table_bytes[i] = key;
                            table_length[i] = r.tag_length;
                            ok = 1'b1;
                            done = 1'b1;
                        end else if (found) begin
                            ok = 1'b1;
                            done = 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (found) begin
                            table_bytes[i] = '0;
                            table_length[i] = '0;
                            ok = 1'b1;
                            done = 1'b1;
                        end
                    end
                    OP_VALIDATE: begin
                        if (found) begin
                            ok = 1'b1;
                            done = 1'b1;
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
        end
        return ok;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    task automatic push_request(input logic [1:0] op, input logic [63:0] bytes,
                                input logic [3:0] len);
        tag_request_t r;
        r.opcode = op;
        r.tag_bytes = bytes;
        r.tag_length = len;
        pending_requests.push_back(r);
    endtask

    // Mostly requests on a small set of known tags so that the table fills, matches
    // and empties; the rest are malformed or near-miss requests.
    task automatic push_random_request();
        int pick;
        int idx;
        logic [1:0]  op;
        logic [63:0] bytes;
        logic [3:0]  len;
        pick = $urandom_range(99);
        idx = $urandom_range(PoolSize - 1);
        bytes = pool_bytes[idx];
        len = pool_length[idx];
        if (pick < 45) begin
            op = OP_ADD;
        end else if (pick < 70) begin
            op = OP_DELETE;
        end else begin
            op = OP_VALIDATE;
        end
        if ($urandom_range(99) < 30) begin
            bytes = bytes | ({$urandom, $urandom} & ~tag_mask(len));
        end
        pick = $urandom_range(99);
        if (pick < 8) begin
            op = 2'($urandom_range(3));
            bytes = {$urandom, $urandom};
            len = 4'($urandom_range(15));
        end else if (pick < 14) begin
            bytes[$urandom_range(8 * int'(len) - 1)] ^= 1'b1;
        end else if (pick < 18) begin
            len = 4'($urandom_range(1, MaxTagBytes));
        end
        push_request(op, bytes, len);
    endtask

    always @(posedge aclk) begin : driver_proc
        tag_request_t next_request;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                ok_expected.push_back(apply_request(request_on_bus));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_request = pending_requests.pop_front();
                    request_on_bus = next_request;
                    s_tdata <= {2'b00, next_request.tag_length, next_request.tag_bytes,
                                next_request.opcode};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor_proc
        logic ok_want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (ok_expected.size() == 0) begin
                    note_failure($sformatf("unexpected result transaction, ok=%0b", m_tdata[0]));
                end else begin
                    ok_want = ok_expected.pop_front();
                    if (m_tdata[0] !== ok_want) begin
                        note_failure($sformatf("ok mismatch: expected %0b, got %0b",
                                               ok_want, m_tdata[0]));
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("tag_id_whitelist_table_test NOT OK");
        $finish;
    end

    initial begin
        for (int i = 0; i < TableSlots; i++) begin
            table_bytes[i] = '0;
            table_length[i] = '0;
        end
        for (int i = 0; i < PoolSize; i++) begin
            pool_length[i] = 4'($urandom_range(1, MaxTagBytes));
            if (i % 2 == 1) begin
                pool_bytes[i] = pool_bytes[i - 1] & tag_mask(pool_length[i]);
            end else begin
                pool_bytes[i] = {$urandom, $urandom} & tag_mask(pool_length[i]);
            end
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Malformed requests: zero length, overlong lengths and the unused opcode.
        push_request(OP_ADD, 64'hffff_ffff_ffff_ffff, 4'd0);
        push_request(OP_DELETE, 64'hffff_ffff_ffff_ffff, 4'd9);
        push_request(OP_VALIDATE, 64'h0123_4567_89ab_cdef, 4'd15);
        push_request(OpUnused, 64'hffff_ffff_ffff_ffff, 4'd8);
        // Full-width tag, a shorter length on the same bytes, and a repeated add.
        push_request(OP_ADD, 64'hffff_ffff_ffff_ffff, 4'd8);
        push_request(OP_VALIDATE, 64'hffff_ffff_ffff_ffff, 4'd7);
        push_request(OP_ADD, 64'hffff_ffff_ffff_ffff, 4'd8);
        // One-byte tag of value zero, then looked up with junk above its length.
        push_request(OP_ADD, 64'hdead_beef_cafe_0000, 4'd1);
        push_request(OP_VALIDATE, 64'h1234_5678_9abc_de00, 4'd1);
        // Fill the remaining slots, then add to a full table.
        for (int k = 1; k <= TableSlots - 2; k++) begin
            push_request(OP_ADD, {48'h0, 8'(k), 8'hc3}, 4'd2);
        end
        push_request(OP_ADD, 64'h0000_0000_0000_5a5a, 4'd2);
        push_request(OP_ADD, {48'h0, 8'd5, 8'hc3}, 4'd2);
        push_request(OP_DELETE, 64'hffff_ffff_ffff_ffff, 4'd8);
        push_request(OP_VALIDATE, 64'hffff_ffff_ffff_ffff, 4'd8);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 52;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 52;
                end
                default: begin
                    sender_idle_pct = 28;
                    receiver_stall_pct = 28;
                end
            endcase
            for (int n = 0; n < RandomPerPhase; n++) begin
                push_random_request();
            end
            while (pending_requests.size() != 0 || s_tvalid || ok_expected.size() != 0) begin
                @(posedge aclk);
            end
        end

        repeat (3 + TableSlots + 16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tag_id_whitelist_table_test OK");
        end else begin
            $display("tag_id_whitelist_table_test NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/twt_pkg.sv
rtl/twt_sequencer.sv
rtl/twt_datapath.sv
rtl/tag_id_whitelist_table.sv
tb/sv/tag_id_whitelist_table_test.sv
